>>> rtl/crcmsb_pkg.sv
// Shared constants for the MSB-first CRC-32 division check.
`default_nettype none

package crcmsb_pkg;

  // Generator polynomial, top bit implied
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // Bytes loaded directly into the remainder before division starts
  localparam logic [2:0] LOAD_BYTES = 3'd4;

  // Byte count saturates here; any value at or above LOAD_BYTES means loaded
  localparam logic [2:0] COUNT_SAT = 3'd5;

  typedef logic [31:0] crc_word_t;
  typedef logic [7:0]  crc_byte_t;
  typedef logic [2:0]  byte_count_t;

endpackage

`default_nettype wire

>>> rtl/crcmsb_in_if.sv
// Byte channel into the CRC check: valid/ready plus data byte and last flag.
`default_nettype none

interface crcmsb_in_if
  import crcmsb_pkg::*;
;
  logic      valid;
  logic      ready;
  crc_byte_t data_byte;
  logic      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/crcmsb_out_if.sv
// Result channel from the CRC check: valid/ready plus CRC value and short flag.
`default_nettype none

interface crcmsb_out_if
  import crcmsb_pkg::*;
;
  logic      valid;
  logic      ready;
  crc_word_t crc_value;
  logic      short_message;

  modport source (output valid, output crc_value, output short_message, input ready);
  modport sink   (input valid, input crc_value, input short_message, output ready);
endinterface

`default_nettype wire

>>> rtl/crcmsb_byte_step.sv
// Eight-bit MSB-first division step of the remainder by the CRC-32 polynomial.
`default_nettype none

module crcmsb_byte_step
  import crcmsb_pkg::*;
(
  input  crc_word_t rem_cur,
  input  crc_byte_t data,
  output crc_word_t rem_next
);

  // Shift each data bit in, top bit first, folding the polynomial on carry-out
  always_comb begin
    crc_word_t r;
    r = rem_cur;
    for (int k = 7; k >= 0; k--) begin
      if (r[31]) begin
        r = {r[30:0], data[k]} ^ CRC_POLY;
      end else begin
        r = {r[30:0], data[k]};
      end
    end
    rem_next = r;
  end

endmodule

`default_nettype wire

>>> rtl/crc32_msb_division_check.sv
// CRC-32 division check, MSB first, polynomial 04C11DB7: top level.
//
// Usage:
//   msg    : one message byte per beat (data_byte) with last_byte on the
//            final byte of the message.
//   result : one beat per message, on its final byte: crc_value is the
//            complemented remainder, or zero with short_message set when
//            the message had four bytes or fewer.
// The first four bytes load the remainder big-endian and complement it;
// each later byte is divided in with one eight-bit step as it is accepted.
// Throughput: one byte per cycle while msg.ready is high, set by the
// combinational byte step between the remainder register and itself.
// The result is registered: it appears in the cycle after its final byte is taken.
// Stall: the result register holds until taken; msg.ready stays high while
// the result register is empty or being drained, so a stalled receiver
// blocks input only once a result is waiting.
// Reset (rst, synchronous): clears the remainder, the byte count and the
// result valid.
`default_nettype none

module crc32_msb_division_check
  import crcmsb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  crcmsb_in_if.sink          msg,
  crcmsb_out_if.source       result
);

  crc_word_t   remainder;
  byte_count_t bytes_seen;
  logic        out_valid;
  crc_word_t   crc_value;
  logic        short_message;

  crc_word_t   rem_step;
  crc_word_t   rem_load;
  crc_word_t   remainder_next;
  byte_count_t bytes_seen_next;
  logic        loaded;
  logic        accept;

  crcmsb_byte_step u_step (
    .rem_cur  (remainder),
    .data     (msg.data_byte),
    .rem_next (rem_step)
  );

  // Take a beat whenever the result register is free or draining
  assign msg.ready = !out_valid || result.ready;
  assign accept    = msg.valid && msg.ready;

  // Load phase or division phase
  always_comb begin
    loaded   = (bytes_seen >= LOAD_BYTES);
    rem_load = {remainder[23:0], msg.data_byte};
    if (bytes_seen == LOAD_BYTES - 3'd1) begin
      rem_load = ~rem_load;
    end
    remainder_next  = loaded ? rem_step : rem_load;
    bytes_seen_next = (bytes_seen < COUNT_SAT) ? bytes_seen + 3'd1 : bytes_seen;
  end

  // Advance the remainder and count; clear both after a final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder  <= '0;
      bytes_seen <= '0;
    end else if (accept) begin
      if (msg.last_byte) begin
        remainder  <= '0;
        bytes_seen <= '0;
      end else begin
        remainder  <= remainder_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && msg.last_byte) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result payload on a final byte
  always_ff @(posedge clk) begin
    if (accept && msg.last_byte) begin
      crc_value     <= loaded ? ~rem_step : '0;
      short_message <= !loaded;
    end
  end

  assign result.valid         = out_valid;
  assign result.crc_value     = crc_value;
  assign result.short_message = short_message;

endmodule

`default_nettype wire
